/* rtl/mecanum_drive_mixer_watchdog_unit_defines.svh */
// ----------------------------------------------------------------------------
// Mecanum drive mixer assertion macros
// Shared assertion macros for the mixer RTL; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef MECANUM_DRIVE_MIXER_WATCHDOG_UNIT_DEFINES_SVH
`define MECANUM_DRIVE_MIXER_WATCHDOG_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define MDMW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A condition that must be followed by another one in the next cycle.
`define MDMW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MDMW_ASSERT(label, clk, rst_n, prop, msg)
`define MDMW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/mdmw_pkg.sv */
// ----------------------------------------------------------------------------
// Mecanum drive mixer package
// Opcodes, register indexes, reset values and the types shared by the blocks.
// ----------------------------------------------------------------------------
package mdmw_pkg;

    // Default depth of the job queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Input opcodes.
    localparam logic [1:0] OP_COMMAND = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_STOP    = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_REFRESH = 2'd1;
    localparam logic [1:0] CFG_LIMIT   = 2'd2;

    // Register reset values.
    localparam logic [15:0] TIMEOUT_RST = 16'd500;
    localparam logic [15:0] REFRESH_RST = 16'd20;
    localparam logic [6:0]  LIMIT_RST   = 7'd100;

    // Largest motor speed magnitude and the last wheel of a group.
    localparam logic [8:0] FULL_SCALE = 9'd127;
    localparam logic [1:0] LAST_MOTOR = 2'd3;

    // One send job: the held axes at the moment of the send.
    typedef struct packed {
        logic signed [7:0] strafe;
        logic signed [7:0] forward;
        logic signed [7:0] turn;
    } t_job;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

/* rtl/mdmw_front.sv */
// ----------------------------------------------------------------------------
// Mecanum drive mixer front end
// Holds the configuration and command state, runs the watchdog and refresh
// timers and queues a send job whenever a group of motor writes is due.
// ----------------------------------------------------------------------------
module mdmw_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // [15:0] strafe_in, [31:16] forward_in, [47:32] turn_in
    input  logic [47:0]        i_s_axis_tdata,
    // [1:0] opcode, [2] strafe_given, [3] forward_given, [4] turn_given
    input  logic [4:0]         i_s_axis_tuser,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  mdmw_pkg::t_qstat   i_qstat,
    output logic               o_push,
    output mdmw_pkg::t_job     o_job
);

    logic [15:0]       r_timeout, r_refresh;
    logic [6:0]        r_limit;
    logic signed [7:0] r_held_x, r_held_y, r_held_z;
    logic signed [7:0] r_sent_x, r_sent_y, r_sent_z;
    logic              r_sent_vld;
    logic [15:0]       r_since_cmd;
    logic              r_armed;
    logic [15:0]       r_since_send;

    logic signed [7:0] n_held_x, n_held_y, n_held_z;
    logic signed [7:0] n_sent_x, n_sent_y, n_sent_z;
    logic              n_sent_vld;
    logic [15:0]       n_since_cmd;
    logic              n_armed;
    logic [15:0]       n_since_send;
    logic              n_push;

    logic              accept;
    logic [1:0]        opcode;

    // Clamp a 16-bit request to plus or minus the limit.
    function automatic logic signed [7:0] clamp_axis(input logic signed [15:0] v,
                                                     input logic [6:0] lim);
        logic signed [15:0] hi;
        logic signed [15:0] lo;
        logic signed [15:0] c;
        hi = $signed({9'd0, lim});
        lo = -hi;
        c  = v;
        if (v > hi) begin
            c = hi;
        end else if (v < lo) begin
            c = lo;
        end
        return c[7:0];
    endfunction

    // Saturating increment of a tick counter.
    function automatic logic [15:0] sat_inc(input logic [15:0] c);
        return (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

    assign o_s_axis_tready = !i_qstat.full;
    assign o_cfg_ready     = 1'b1;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign opcode          = i_s_axis_tuser[1:0];

    // Command state update, watchdog and send decision.
    always_comb begin
        logic run;
        logic changed;
        n_held_x     = r_held_x;
        n_held_y     = r_held_y;
        n_held_z     = r_held_z;
        n_sent_x     = r_sent_x;
        n_sent_y     = r_sent_y;
        n_sent_z     = r_sent_z;
        n_sent_vld   = r_sent_vld;
        n_since_cmd  = r_since_cmd;
        n_armed      = r_armed;
        n_since_send = r_since_send;
        n_push       = 1'b0;
        run          = 1'b0;
        changed      = 1'b0;
        if (accept) begin
            case (opcode)
                mdmw_pkg::OP_COMMAND: begin
                    if (i_s_axis_tuser[2]) begin
                        n_held_x = clamp_axis(i_s_axis_tdata[15:0], r_limit);
                    end
                    if (i_s_axis_tuser[3]) begin
                        n_held_y = clamp_axis(i_s_axis_tdata[31:16], r_limit);
                    end
                    if (i_s_axis_tuser[4]) begin
                        n_held_z = clamp_axis(i_s_axis_tdata[47:32], r_limit);
                    end
                    n_since_cmd = 16'd0;
                    n_armed     = 1'b1;
                    run         = 1'b1;
                end
                mdmw_pkg::OP_TICK: begin
                    n_since_cmd  = sat_inc(r_since_cmd);
                    n_since_send = sat_inc(r_since_send);
                    run          = 1'b1;
                end
                mdmw_pkg::OP_STOP: begin
                    // Stop zeroes the command; the zero job gives zero writes.
                    n_held_x    = 8'sd0;
                    n_held_y    = 8'sd0;
                    n_held_z    = 8'sd0;
                    n_armed     = 1'b0;
                    n_since_cmd = 16'd0;
                    n_sent_vld  = 1'b0;
                    n_push      = 1'b1;
                end
                default: begin
                end
            endcase
        end
        if (run) begin
            // Watchdog expiry clears the held command.
            if (n_armed && (n_since_cmd > r_timeout)) begin
                n_held_x    = 8'sd0;
                n_held_y    = 8'sd0;
                n_held_z    = 8'sd0;
                n_armed     = 1'b0;
                n_since_cmd = 16'd0;
            end
            changed = !r_sent_vld || (n_held_x != r_sent_x) ||
                      (n_held_y != r_sent_y) || (n_held_z != r_sent_z);
            if (changed || (n_since_send >= r_refresh)) begin
                n_since_send = 16'd0;
                n_sent_x     = n_held_x;
                n_sent_y     = n_held_y;
                n_sent_z     = n_held_z;
                n_sent_vld   = 1'b1;
                n_push       = 1'b1;
            end
        end
    end

    assign o_push          = n_push;
    assign o_job.strafe    = n_held_x;
    assign o_job.forward   = n_held_y;
    assign o_job.turn      = n_held_z;

    // State and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout    <= mdmw_pkg::TIMEOUT_RST;
            r_refresh    <= mdmw_pkg::REFRESH_RST;
            r_limit      <= mdmw_pkg::LIMIT_RST;
            r_held_x     <= 8'sd0;
            r_held_y     <= 8'sd0;
            r_held_z     <= 8'sd0;
            r_sent_x     <= 8'sd0;
            r_sent_y     <= 8'sd0;
            r_sent_z     <= 8'sd0;
            r_sent_vld   <= 1'b0;
            r_since_cmd  <= 16'd0;
            r_armed      <= 1'b0;
            r_since_send <= 16'd0;
        end else begin
            r_held_x     <= n_held_x;
            r_held_y     <= n_held_y;
            r_held_z     <= n_held_z;
            r_sent_x     <= n_sent_x;
            r_sent_y     <= n_sent_y;
            r_sent_z     <= n_sent_z;
            r_sent_vld   <= n_sent_vld;
            r_since_cmd  <= n_since_cmd;
            r_armed      <= n_armed;
            r_since_send <= n_since_send;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    mdmw_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data;
                    mdmw_pkg::CFG_REFRESH: r_refresh <= i_cfg_data;
                    mdmw_pkg::CFG_LIMIT:   r_limit   <= i_cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

/* rtl/mdmw_fifo.sv */
// ----------------------------------------------------------------------------
// Mecanum drive mixer job queue
// Short queue of send jobs that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "mecanum_drive_mixer_watchdog_unit_defines.svh"

module mdmw_fifo #(
    parameter int DEPTH = mdmw_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mdmw_pkg::t_job     i_job,
    input  logic               i_pop,
    output mdmw_pkg::t_job     o_job,
    output mdmw_pkg::t_qstat   o_qstat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mdmw_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;

    // Wrap a pointer at the queue depth.
    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_qstat.full  = (r_count == CW'(DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_job         = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `MDMW_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_qstat.full), "push into full queue")
    `MDMW_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && o_qstat.empty), "pop from empty queue")

endmodule

/* rtl/mdmw_back.sv */
// ----------------------------------------------------------------------------
// Mecanum drive mixer back end
// Mixes one job into four wheel speeds, scales them with a shared radix-4
// divider when the peak exceeds full scale and emits four motor writes.
// ----------------------------------------------------------------------------
`include "mecanum_drive_mixer_watchdog_unit_defines.svh"

module mdmw_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mdmw_pkg::t_qstat   i_qstat,
    input  mdmw_pkg::t_job     i_job,
    output logic               o_pop,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // [7:0] motor_speed
    output logic [7:0]         o_m_axis_tdata,
    // [1:0] motor_index
    output logic [1:0]         o_m_axis_tuser,
    output logic               o_m_axis_tlast
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOAD  = 4'b0010,
        S_DIV   = 4'b0100,
        S_WRITE = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [1:0]        r_idx, n_idx;
    logic [1:0]        r_step, n_step;
    logic              r_o_vld, n_o_vld;

    logic signed [9:0] r_mix [4];
    logic [8:0]        r_peak;
    logic              r_neg;
    logic [9:0]        r_rem;
    logic [7:0]        r_dq;
    logic [7:0]        r_speed;
    logic [1:0]        r_o_idx;
    logic [7:0]        r_o_speed;
    logic              r_o_last;

    logic signed [9:0] mix [4];
    logic [8:0]        mag [4];
    logic [8:0]        peak;
    logic [8:0]        cur_mag;
    logic [16:0]       dividend;
    logic [9:0]        divisor;
    logic [9:0]        div_rem;
    logic [7:0]        div_dq;
    logic              load_out;

    // Wheel mix and peak magnitude of the job at the queue head.
    always_comb begin
        logic signed [9:0] x, y, z;
        logic [8:0] pa, pb;
        x = 10'(i_job.strafe);
        y = 10'(i_job.forward);
        z = 10'(i_job.turn);
        mix[0] = y + x + z;
        mix[1] = y - x - z;
        mix[2] = y - x + z;
        mix[3] = y + x - z;
        for (int i = 0; i < 4; i++) begin
            mag[i] = mix[i][9] ? 9'(-mix[i]) : mix[i][8:0];
        end
        pa   = (mag[0] > mag[1]) ? mag[0] : mag[1];
        pb   = (mag[2] > mag[3]) ? mag[2] : mag[3];
        peak = (pa > pb) ? pa : pb;
    end

    // Numerator 2*|m|*127 + peak over divisor 2*peak.
    assign cur_mag  = r_mix[r_idx][9] ? 9'(-r_mix[r_idx]) : r_mix[r_idx][8:0];
    assign dividend = {({cur_mag, 7'd0} - {7'd0, cur_mag}), 1'b0} + {8'd0, r_peak};
    assign divisor  = {r_peak, 1'b0};

    // Two restoring divide steps per cycle.
    always_comb begin
        logic [10:0] t;
        div_rem = r_rem;
        div_dq  = r_dq;
        for (int k = 0; k < 2; k++) begin
            t = {div_rem, div_dq[7]};
            if (t >= {1'b0, divisor}) begin
                div_rem = 10'(t - {1'b0, divisor});
                div_dq  = {div_dq[6:0], 1'b1};
            end else begin
                div_rem = t[9:0];
                div_dq  = {div_dq[6:0], 1'b0};
            end
        end
    end

    assign o_pop    = (r_state == S_IDLE) && !i_qstat.empty;
    assign load_out = (r_state == S_WRITE) && (!r_o_vld || i_m_axis_tready);

    // Sequencer over the four wheels.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_step  = r_step;
        n_o_vld = r_o_vld && !i_m_axis_tready;
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_state = S_LOAD;
                    n_idx   = 2'd0;
                end
            end
            S_LOAD: begin
                n_step  = 2'd0;
                n_state = (r_peak > mdmw_pkg::FULL_SCALE) ? S_DIV : S_WRITE;
            end
            S_DIV: begin
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (load_out) begin
                    n_o_vld = 1'b1;
                    if (r_idx == mdmw_pkg::LAST_MOTOR) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 2'd1;
                        n_state = S_LOAD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= 2'd0;
            r_step  <= 2'd0;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_step  <= n_step;
            r_o_vld <= n_o_vld;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int i = 0; i < 4; i++) begin
                r_mix[i] <= mix[i];
            end
            r_peak <= peak;
        end
        if (r_state == S_LOAD) begin
            r_neg   <= r_mix[r_idx][9];
            r_rem   <= {1'b0, dividend[16:8]};
            r_dq    <= dividend[7:0];
            r_speed <= r_mix[r_idx][7:0];
        end
        if (r_state == S_DIV) begin
            r_rem <= div_rem;
            r_dq  <= div_dq;
            if (r_step == 2'd3) begin
                r_speed <= r_neg ? 8'(-div_dq) : div_dq;
            end
        end
        if (load_out) begin
            r_o_idx   <= r_idx;
            r_o_speed <= r_speed;
            r_o_last  <= (r_idx == mdmw_pkg::LAST_MOTOR);
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = r_o_speed;
    assign o_m_axis_tuser  = r_o_idx;
    assign o_m_axis_tlast  = r_o_last;

    `MDMW_ASSERT(a_last_on_fourth, i_clk, i_rst_n, !r_o_vld || (r_o_last == (r_o_idx == mdmw_pkg::LAST_MOTOR)), "last flag off the fourth wheel")
    `MDMW_ASSERT(a_speed_range, i_clk, i_rst_n, !r_o_vld || (r_o_speed != 8'h80), "motor speed out of range")
    `MDMW_ASSERT_NEXT(a_pop_starts, i_clk, i_rst_n, o_pop, (r_state == S_LOAD) && (r_idx == 2'd0), "group did not start at wheel zero")

endmodule

/* rtl/mecanum_drive_mixer_watchdog_unit.sv */
// Flow: a command, tick or stop that triggers a group queues a job on acceptance; the back end
// pops it, then per wheel loads in S_LOAD, divides in S_DIV when the peak exceeds full scale
// and writes in S_WRITE, using the shared radix-4 divider. Items that trigger no writes queue
// no job, but are still accepted only while the queue is not full.
// Reset: synchronous active low; registers return to 500/20/100, command state clears.
// ----------------------------------------------------------------------------
// Mecanum drive mixer with watchdog
// Top level: front end with timers, job queue and mixing/scaling back end.
// ----------------------------------------------------------------------------
module mecanum_drive_mixer_watchdog_unit #(
    parameter int QUEUE_DEPTH = mdmw_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [15:0] strafe_in, [31:16] forward_in, [47:32] turn_in
    input  logic [47:0] i_s_axis_tdata,
    // [1:0] opcode, [2] strafe_given, [3] forward_given, [4] turn_given
    input  logic [4:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] motor_speed
    output logic [7:0]  o_m_axis_tdata,
    // [1:0] motor_index
    output logic [1:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    mdmw_pkg::t_qstat qstat;
    mdmw_pkg::t_job   push_job, head_job;
    logic             push, pop;

    // Front end: configuration, timers and send decision.
    mdmw_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_qstat         (qstat),
        .o_push          (push),
        .o_job           (push_job)
    );

    // Job queue.
    mdmw_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_qstat (qstat)
    );

    // Back end: mixing, scaling and motor writes.
    mdmw_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_qstat         (qstat),
        .i_job           (head_job),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

/* tb/mecanum_drive_mixer_watchdog_unit_tb.sv */
// ----------------------------------------------------------------------------
// Mecanum drive mixer testbench
// Streams command, tick and stop words into the mixer under random flow
// control and checks every motor write against an in-bench model of the
// clamping, watchdog, refresh timer and wheel mixing with scaling.
// ----------------------------------------------------------------------------
module mecanum_drive_mixer_watchdog_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Opcode 3 has no name in the package; the block must ignore it.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;

    // One expected motor write.
    typedef struct packed {
        logic [1:0] wheel;
        logic [7:0] speed;
        logic       last;
    } t_wheel_write;

    // Predicts the motor writes of each accepted word and checks them in order.
    class t_mixer_scoreboard;
        logic [15:0]       timeout_ticks;
        logic [15:0]       refresh_ticks;
        logic [6:0]        command_limit;
        logic signed [7:0] held_x, held_y, held_z;
        logic signed [7:0] sent_x, sent_y, sent_z;
        bit                sent_valid;
        bit                armed;
        logic [15:0]       since_command;
        logic [15:0]       since_send;
        t_wheel_write      expected_writes[$];
        int                errors;

        function new();
            timeout_ticks = mdmw_pkg::TIMEOUT_RST;
            refresh_ticks = mdmw_pkg::REFRESH_RST;
            command_limit = mdmw_pkg::LIMIT_RST;
            held_x = 0; held_y = 0; held_z = 0;
            sent_x = 0; sent_y = 0; sent_z = 0;
            sent_valid = 0;
            armed = 0;
            since_command = 0;
            since_send = 0;
            errors = 0;
        endfunction

        function void set_register(logic [1:0] index, logic [15:0] value);
            case (index)
                mdmw_pkg::CFG_TIMEOUT: timeout_ticks = value;
                mdmw_pkg::CFG_REFRESH: refresh_ticks = value;
                mdmw_pkg::CFG_LIMIT:   command_limit = value[6:0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return expected_writes.size();
        endfunction

        function logic signed [7:0] clamp_axis(logic [15:0] raw);
            int v;
            int lim;
            v = int'($signed(raw));
            lim = int'(command_limit);
            if (v > lim) v = lim;
            if (v < -lim) v = -lim;
            return v[7:0];
        endfunction

        function logic [15:0] bump(logic [15:0] c);
            return (c == 16'hFFFF) ? c : c + 16'd1;
        endfunction

        // Mix the held axes into four wheel speeds, scaled down past full scale.
        function void queue_group();
            int m[4];
            int peak;
            int mag;
            int q;
            t_wheel_write w;
            m[0] = int'(held_y) + int'(held_x) + int'(held_z);
            m[1] = int'(held_y) - int'(held_x) - int'(held_z);
            m[2] = int'(held_y) - int'(held_x) + int'(held_z);
            m[3] = int'(held_y) + int'(held_x) - int'(held_z);
            peak = 0;
            for (int i = 0; i < 4; i++) begin
                mag = (m[i] < 0) ? -m[i] : m[i];
                if (mag > peak) peak = mag;
            end
            for (int i = 0; i < 4; i++) begin
                if (peak > int'(mdmw_pkg::FULL_SCALE)) begin
                    mag = (m[i] < 0) ? -m[i] : m[i];
                    q = (2 * mag * int'(mdmw_pkg::FULL_SCALE) + peak) / (2 * peak);
                    m[i] = (m[i] < 0) ? -q : q;
                end
                w.wheel = i[1:0];
                w.speed = m[i][7:0];
                w.last = (w.wheel == mdmw_pkg::LAST_MOTOR);
                expected_writes.push_back(w);
            end
        endfunction

        // Update the model with one accepted word and queue its writes.
        function void note_item(logic [1:0] op, logic [15:0] x, logic [15:0] y,
                                logic [15:0] z, logic [2:0] given);
            bit changed;
            t_wheel_write w;
            case (op)
                mdmw_pkg::OP_STOP: begin
                    held_x = 0; held_y = 0; held_z = 0;
                    armed = 0;
                    since_command = 0;
                    sent_valid = 0;
                    for (int i = 0; i < 4; i++) begin
                        w.wheel = i[1:0];
                        w.speed = 8'd0;
                        w.last = (w.wheel == mdmw_pkg::LAST_MOTOR);
                        expected_writes.push_back(w);
                    end
                    return;
                end
                mdmw_pkg::OP_COMMAND: begin
                    if (given[0]) held_x = clamp_axis(x);
                    if (given[1]) held_y = clamp_axis(y);
                    if (given[2]) held_z = clamp_axis(z);
                    since_command = 0;
                    armed = 1;
                end
                mdmw_pkg::OP_TICK: begin
                    since_command = bump(since_command);
                    since_send = bump(since_send);
                end
                default: return;
            endcase

            // Watchdog: drop the command once the timeout has been exceeded.
            if (armed && since_command > timeout_ticks) begin
                held_x = 0; held_y = 0; held_z = 0;
                armed = 0;
                since_command = 0;
            end

            changed = !sent_valid || held_x != sent_x || held_y != sent_y ||
                      held_z != sent_z;
            if (!changed && since_send < refresh_ticks) return;

            since_send = 0;
            sent_x = held_x; sent_y = held_y; sent_z = held_z;
            sent_valid = 1;
            queue_group();
        endfunction

        function void report(string what);
            errors++;
            if (errors <= MAX_REPORTS) $display("%s", what);
        endfunction

        function void check_write(logic [1:0] wheel, logic [7:0] speed, logic last);
            t_wheel_write want;
            if (expected_writes.size() == 0) begin
                report($sformatf("ERROR: unexpected write wheel %0d speed %0d last %0b",
                                 wheel, $signed(speed), last));
                return;
            end
            want = expected_writes.pop_front();
            if (want.wheel != wheel || want.speed != speed || want.last != last)
                report($sformatf({"ERROR: write mismatch, expected wheel %0d speed %0d ",
                                  "last %0b, got wheel %0d speed %0d last %0b"},
                                 want.wheel, $signed(want.speed), want.last,
                                 wheel, $signed(speed), last));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    // [15:0] strafe_in, [31:16] forward_in, [47:32] turn_in
    logic [47:0] i_s_axis_tdata;
    // [1:0] opcode, [2] strafe_given, [3] forward_given, [4] turn_given
    logic [4:0]  i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // [7:0] motor_speed
    logic [7:0]  o_m_axis_tdata;
    // [1:0] motor_index
    logic [1:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    t_mixer_scoreboard board = new();
    int   sender_idle_pct = 30;
    int   sink_idle_pct = 83;
    logic sink_blocked = 1'b0;
    event long_sink_hold;

    mecanum_drive_mixer_watchdog_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .o_m_axis_tlast (o_m_axis_tlast),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Motor write sink: check each accepted word, then choose the next ready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_write(o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast);
        if (sink_blocked)
            i_m_axis_tready <= 1'b0;
        else
            i_m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Long sink stall, counted here so that the sender keeps pushing meanwhile.
    initial begin
        forever begin
            @(long_sink_hold);
            sink_blocked <= 1'b1;
            repeat (400) @(posedge i_clk);
            sink_blocked <= 1'b0;
        end
    end

    // Offer one input word, wait for its acceptance, then maybe idle a while.
    task automatic send_item(logic [1:0] op, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z, logic [2:0] given);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {z, y, x};
        i_s_axis_tuser <= {given, op};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        board.note_item(op, x, y, z, given);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic write_register(logic [1:0] index, logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.set_register(index, value);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop sending, wait for every expected write, then let the block settle.
    task automatic drain_writes(int settle);
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic set_all(logic [15:0] timeout, logic [15:0] refresh, logic [15:0] limit);
        write_register(mdmw_pkg::CFG_TIMEOUT, timeout);
        write_register(mdmw_pkg::CFG_REFRESH, refresh);
        write_register(mdmw_pkg::CFG_LIMIT, limit);
    endtask

    // Axis value biased toward the clamp edges and the 16-bit extremes.
    function automatic logic [15:0] pick_axis();
        int v;
        case ($urandom_range(7))
            0: v = $urandom_range(65535);
            1: v = -32768;
            2: v = 32767;
            3: begin
                v = int'(board.command_limit) + $urandom_range(2) - 1;
                if ($urandom_range(1)) v = -v;
            end
            default: v = $urandom_range(300) - 150;
        endcase
        return v[15:0];
    endfunction

    // Random words: mostly commands and ticks, some stops and ignored opcodes.
    task automatic random_segment(int count);
        int sent;
        int roll;
        logic [1:0] op;
        logic [2:0] given;
        sent = 0;
        while (sent < count) begin
            roll = $urandom_range(99);
            if (roll < 38) op = mdmw_pkg::OP_COMMAND;
            else if (roll < 88) op = mdmw_pkg::OP_TICK;
            else if (roll < 95) op = mdmw_pkg::OP_STOP;
            else op = OP_UNUSED;
            given[0] = ($urandom_range(99) < 80);
            given[1] = ($urandom_range(99) < 80);
            given[2] = ($urandom_range(99) < 80);
            send_item(op, pick_axis(), pick_axis(), pick_axis(), given);
            if (op != OP_UNUSED) sent++;
            // Now and then the sender waits for the block to empty.
            if ($urandom_range(99) < 2) drain_writes(0);
        end
    endtask

    // Main sequence.
    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words under the reset settings.
        send_item(mdmw_pkg::OP_COMMAND, 16'h7FFF, 16'h8000, 16'h0000, 3'b111);
        send_item(mdmw_pkg::OP_COMMAND, 16'd100, 16'd100, 16'd100, 3'b111);
        send_item(mdmw_pkg::OP_COMMAND, 16'h1234, 16'h4321, 16'hFFFF, 3'b000);
        send_item(mdmw_pkg::OP_COMMAND, 16'hFFFF, 16'd0, 16'd0, 3'b001);
        send_item(mdmw_pkg::OP_COMMAND, 16'd0, 16'hFF9C, 16'd0, 3'b010);
        send_item(mdmw_pkg::OP_COMMAND, 16'd0, 16'd0, 16'd101, 3'b100);
        send_item(mdmw_pkg::OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b111);
        send_item(OP_UNUSED, 16'h5555, 16'hAAAA, 16'h0F0F, 3'b111);
        send_item(mdmw_pkg::OP_STOP, 16'hAAAA, 16'h5555, 16'hF0F0, 3'b000);
        send_item(mdmw_pkg::OP_STOP, 16'd0, 16'd0, 16'd0, 3'b000);
        drain_writes(64);

        // Zero limit, zero timeout and zero refresh.
        set_all(16'd0, 16'd0, 16'd0);
        send_item(mdmw_pkg::OP_COMMAND, 16'd5, 16'hFFFB, 16'd5, 3'b111);
        send_item(mdmw_pkg::OP_TICK, 16'd0, 16'd0, 16'd0, 3'b000);
        send_item(mdmw_pkg::OP_TICK, 16'd0, 16'd0, 16'd0, 3'b000);
        send_item(mdmw_pkg::OP_COMMAND, 16'd0, 16'd0, 16'd0, 3'b000);
        drain_writes(64);

        // Full limit with scaling, then the watchdog clearing the command.
        set_all(16'd2, 16'd3, 16'd127);
        send_item(mdmw_pkg::OP_COMMAND, 16'd127, 16'd127, 16'd127, 3'b111);
        send_item(mdmw_pkg::OP_COMMAND, 16'h8000, 16'h8000, 16'h8000, 3'b111);
        send_item(mdmw_pkg::OP_COMMAND, 16'd127, 16'hFF81, 16'd60, 3'b111);
        send_item(mdmw_pkg::OP_TICK, 16'd0, 16'd0, 16'd0, 3'b000);
        send_item(mdmw_pkg::OP_TICK, 16'd0, 16'd0, 16'd0, 3'b000);
        send_item(mdmw_pkg::OP_TICK, 16'd0, 16'd0, 16'd0, 3'b000);
        send_item(mdmw_pkg::OP_TICK, 16'd0, 16'd0, 16'd0, 3'b000);
        send_item(mdmw_pkg::OP_TICK, 16'd0, 16'd0, 16'd0, 3'b000);
        send_item(mdmw_pkg::OP_TICK, 16'd0, 16'd0, 16'd0, 3'b000);
        drain_writes(64);

        // Random segments: three flow-control modes, several register settings.
        for (int seg = 0; seg < 9; seg++) begin
            case (seg / 3)
                0: begin sender_idle_pct = 30; sink_idle_pct = 83; end
                1: begin sender_idle_pct = 83; sink_idle_pct = 30; end
                default: begin sender_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            if (seg == 2)
                set_all(16'd65535, 16'd65535, 16'd127);
            else if (seg == 5)
                set_all(16'd1, 16'd1, 16'd1);
            else
                set_all(16'($urandom_range(1, 40)), 16'($urandom_range(1, 30)),
                        16'($urandom_range(1, 127)));
            if (seg == 0 || seg == 6) -> long_sink_hold;
            random_segment(47);
            drain_writes(64);
        end

        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

/* mecanum_drive_mixer_watchdog_unit.f */
+incdir+rtl
rtl/mdmw_pkg.sv
rtl/mdmw_front.sv
rtl/mdmw_fifo.sv
rtl/mdmw_back.sv
rtl/mecanum_drive_mixer_watchdog_unit.sv
tb/mecanum_drive_mixer_watchdog_unit_tb.sv
